[rtl/dilated_causal_conv1d_stream_macros.svh]
// Assertion macros shared by the convolution block.
// Unless ASSERT_OFF is defined, each macro places one labeled concurrent
// assertion, sampled on the rising clock edge and disabled while reset is high.
`ifndef DILATED_CAUSAL_CONV1D_STREAM_MACROS_SVH
`define DILATED_CAUSAL_CONV1D_STREAM_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication: whenever ante holds, cons holds too.
`define DCC1D_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define DCC1D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DCC1D_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define DCC1D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/dcc1d_pkg.sv]
`default_nettype none

package dcc1d_pkg;

   // Default sizes of the stores.
   localparam int DEF_MAX_IN_CH  = 16;
   localparam int DEF_MAX_OUT_CH = 16;
   localparam int DEF_MAX_TAPS   = 8;
   localparam int DEF_MAX_ORDER  = 512;

   // Dilation is clamped to this many frames.
   localparam int DIL_MAX   = 64;
   // Q4.12 values.
   localparam int FRAC_BITS = 12;
   localparam int VALUE_W   = 16;
   localparam int DIL_W     = 7;

   // Configuration port.
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS_USED       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DILATION        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IN_CH_USED      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_CH_USED     = 2'd3;

   // Request function codes.
   localparam logic [1:0] FUNC_PUSH   = 2'd0;
   localparam logic [1:0] FUNC_WEIGHT = 2'd1;
   localparam logic [1:0] FUNC_BIAS   = 2'd2;

   typedef struct packed {
      logic [1:0]                func;
      logic [2:0]                tap_index;
      logic [3:0]                in_index;
      logic [3:0]                out_index;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0]                result_channel;
      logic signed [VALUE_W-1:0] result_value;
      logic                      frame_last;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/dcc1d_mod_unit.sv]
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle, DVD_W bits per
// operation. The remainder is valid in the cycle in which done is high.
module dcc1d_mod_unit #(
   parameter int DVD_W = 9,
   parameter int DVS_W = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DVS_W-1:0]      remainder
);

   localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] rem_in;
   logic [DVS_W:0]   shift_c;

   // Bring down the next dividend bit and subtract the divisor if it fits.
   always_comb begin
      shift_c = {rem_ff, dvd_ff[DVD_W-1]};
      if (shift_c >= {1'b0, dvs_ff}) begin
         rem_in = DVS_W'(shift_c - {1'b0, dvs_ff});
      end else begin
         rem_in = DVS_W'(shift_c);
      end
   end

   // Step sequencing.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= dvd_ff << 1;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[rtl/dilated_causal_conv1d_stream.sv]
`default_nettype none
`include "dilated_causal_conv1d_stream_macros.svh"

// Streaming dilated causal 1-D convolution over Q4.12 samples. Each request
// either writes one kernel weight, writes one output-channel bias, or pushes
// one input-channel sample into a circular history held in block RAM; the
// sample of the last used input channel completes a frame and produces one
// result per used output channel, in channel order, with frame_last on the
// final one. After reset the block sweeps both RAMs to zero, one address per
// cycle, with a shared counter over 2**max(clog2(MAX_ORDER)+clog2(MAX_IN_CH),
// clog2(MAX_TAPS)+clog2(MAX_IN_CH)+clog2(MAX_OUT_CH)) addresses (8192 at the
// defaults); configuration writes are taken during the sweep but requests are
// not. Weight, bias and ignored requests are done as they are taken; an
// unused-channel sample passes the check state, and any other sample the
// check and history-write states. A frame-closing sample then runs through
// the single multiply-accumulate unit, which reads one history word and one
// weight word per cycle; each result then waits in the output register only
// while the consumer stalls. A sample may add one or two remainder passes,
// when the stored write position or the dilation is not below the history
// order.
module dilated_causal_conv1d_stream #(
   parameter int MAX_IN_CH  = dcc1d_pkg::DEF_MAX_IN_CH,
   parameter int MAX_OUT_CH = dcc1d_pkg::DEF_MAX_OUT_CH,
   parameter int MAX_TAPS   = dcc1d_pkg::DEF_MAX_TAPS,
   parameter int MAX_ORDER  = dcc1d_pkg::DEF_MAX_ORDER
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire dcc1d_pkg::req_type                      req_data,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output dcc1d_pkg::rsp_type                           rsp_data,
   input  wire logic                                    csr_we,
   input  wire logic [dcc1d_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [dcc1d_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import dcc1d_pkg::*;

   localparam int IC_W    = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
   localparam int OC_W    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
   localparam int TAP_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int POS_W   = $clog2(MAX_ORDER);
   localparam int ORD_W   = $clog2(MAX_ORDER + 1);
   localparam int HIST_AW = POS_W + IC_W;
   localparam int W_AW    = TAP_W + IC_W + OC_W;
   localparam int CLR_W   = (HIST_AW > W_AW) ? HIST_AW : W_AW;
   localparam int ACC_W   = 32 + $clog2(MAX_TAPS * MAX_IN_CH + 1);
   localparam int SH_W    = ACC_W - FRAC_BITS;
   localparam int MOD_W   = (POS_W > DIL_W) ? POS_W : DIL_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_PMOD,
      ST_HWRITE,
      ST_DMOD,
      ST_OSTART,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Configuration registers.
   logic [3:0]       taps_ff;
   logic [DIL_W-1:0] dil_ff;
   logic [4:0]       inch_ff;
   logic [4:0]       outch_ff;

   // Clamped configuration.
   logic [3:0]       nt_c;
   logic [DIL_W-1:0] d_c;
   logic [4:0]       nic_c;
   logic [4:0]       noc_c;
   logic [10:0]      raw_order_c;
   logic [ORD_W-1:0] order_c;
   logic [TAP_W-1:0] nt_m1_ff;
   logic [DIL_W-1:0] d_ff;
   logic [IC_W-1:0]  nic_m1_ff;
   logic [OC_W-1:0]  noc_m1_ff;
   logic [ORD_W-1:0] order_ff;

   // Sequencer state.
   state_type                 state_ff;
   logic [CLR_W-1:0]          clr_cnt_ff;
   logic [3:0]                ic_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [POS_W-1:0]          wp_ff;
   logic [POS_W-1:0]          wp_in;
   logic [POS_W-1:0]          p_ff;
   logic [POS_W-1:0]          dm_ff;
   logic [POS_W-1:0]          back_ff;
   logic [POS_W-1:0]          back_in;
   logic [POS_W-1:0]          rp_ff;
   logic [POS_W-1:0]          rp_in;
   logic [TAP_W-1:0]          j_ff;
   logic [IC_W-1:0]           c_ff;
   logic [OC_W-1:0]           o_ff;
   logic [ORD_W:0]            bsum_c;
   logic [ORD_W:0]            pnext_c;

   // Memories and the multiply-accumulate pipeline.
   logic signed [VALUE_W-1:0] hist_mem [2**HIST_AW];
   logic signed [VALUE_W-1:0] w_mem [2**W_AW];
   logic signed [VALUE_W-1:0] bias_ff [MAX_OUT_CH];
   logic                      hist_we;
   logic [HIST_AW-1:0]        hist_wa;
   logic [HIST_AW-1:0]        hist_ra;
   logic signed [VALUE_W-1:0] hist_wd;
   logic signed [VALUE_W-1:0] hist_rd_ff;
   logic                      w_we;
   logic [W_AW-1:0]           w_wa;
   logic [W_AW-1:0]           w_ra;
   logic signed [VALUE_W-1:0] w_wd;
   logic signed [VALUE_W-1:0] w_rd_ff;
   logic                      v1_ff;
   logic                      v2_ff;
   logic signed [31:0]        prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;

   // Result path.
   logic signed [SH_W-1:0]    shifted_c;
   logic signed [VALUE_W-1:0] sat_c;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;
   logic                      rsp_load;

   // Remainder unit.
   logic                      mod_start;
   logic [MOD_W-1:0]          mod_dvd;
   logic                      mod_done;
   logic [ORD_W-1:0]          mod_rem;

   // Request decode.
   logic req_fire;
   logic weight_ok;
   logic bias_ok;
   logic ch_unused;
   logic ch_last;
   logic wp_ge;
   logic d_ge;
   logic last_mac;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign weight_ok = req_fire && (req_data.func == FUNC_WEIGHT) &&
                      (32'(req_data.tap_index) < MAX_TAPS) &&
                      (32'(req_data.in_index) < MAX_IN_CH) &&
                      (32'(req_data.out_index) < MAX_OUT_CH);
   assign bias_ok   = req_fire && (req_data.func == FUNC_BIAS) &&
                      (32'(req_data.out_index) < MAX_OUT_CH);
   assign ch_unused = 32'(ic_ff) > 32'(nic_m1_ff);
   assign ch_last   = 32'(ic_ff) == 32'(nic_m1_ff);
   assign wp_ge     = ORD_W'(wp_ff) >= order_ff;
   assign d_ge      = 32'(d_ff) >= 32'(order_ff);
   assign last_mac  = (c_ff == nic_m1_ff) && (j_ff == nt_m1_ff);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff  <= 4'd1;
         dil_ff   <= DIL_W'(1);
         inch_ff  <= 5'd1;
         outch_ff <= 5'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TAPS_USED:   taps_ff  <= csr_wdata[3:0];
            CSR_DILATION:    dil_ff   <= csr_wdata[DIL_W-1:0];
            CSR_IN_CH_USED:  inch_ff  <= csr_wdata[4:0];
            CSR_OUT_CH_USED: outch_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Clamp the registers to their usable ranges and derive the history order.
   always_comb begin
      if (taps_ff == '0) begin
         nt_c = 4'd1;
      end else if (32'(taps_ff) > MAX_TAPS) begin
         nt_c = 4'(MAX_TAPS);
      end else begin
         nt_c = taps_ff;
      end
      if (dil_ff == '0) begin
         d_c = DIL_W'(1);
      end else if (32'(dil_ff) > DIL_MAX) begin
         d_c = DIL_W'(DIL_MAX);
      end else begin
         d_c = dil_ff;
      end
      if (inch_ff == '0) begin
         nic_c = 5'd1;
      end else if (32'(inch_ff) > MAX_IN_CH) begin
         nic_c = 5'(MAX_IN_CH);
      end else begin
         nic_c = inch_ff;
      end
      if (outch_ff == '0) begin
         noc_c = 5'd1;
      end else if (32'(outch_ff) > MAX_OUT_CH) begin
         noc_c = 5'(MAX_OUT_CH);
      end else begin
         noc_c = outch_ff;
      end
      raw_order_c = 11'(nt_c - 4'd1) * 11'(d_c) + 11'd1;
      if (32'(raw_order_c) > MAX_ORDER) begin
         order_c = ORD_W'(MAX_ORDER);
      end else begin
         order_c = ORD_W'(raw_order_c);
      end
   end

   always_ff @(posedge clock) begin
      nt_m1_ff  <= TAP_W'(nt_c - 4'd1);
      d_ff      <= d_c;
      nic_m1_ff <= IC_W'(nic_c - 5'd1);
      noc_m1_ff <= OC_W'(noc_c - 5'd1);
      order_ff  <= order_c;
   end

   // Tap offset and read position for the next tap, both modulo the order, and the next write position.
   always_comb begin
      bsum_c = (ORD_W + 1)'(back_ff) + (ORD_W + 1)'(dm_ff);
      if (bsum_c >= (ORD_W + 1)'(order_ff)) begin
         back_in = POS_W'(bsum_c - (ORD_W + 1)'(order_ff));
      end else begin
         back_in = POS_W'(bsum_c);
      end
      if (p_ff >= back_in) begin
         rp_in = p_ff - back_in;
      end else begin
         rp_in = POS_W'((ORD_W + 1)'(p_ff) + (ORD_W + 1)'(order_ff) - (ORD_W + 1)'(back_in));
      end
      pnext_c = (ORD_W + 1)'(p_ff) + (ORD_W + 1)'(1);
      if (pnext_c == (ORD_W + 1)'(order_ff)) begin
         wp_in = '0;
      end else begin
         wp_in = POS_W'(pnext_c);
      end
   end

   // Remainder passes for a stale write position or a dilation at or above
   // the order.
   assign mod_start = ((state_ff == ST_CHECK) && !ch_unused && wp_ge) ||
                      ((state_ff == ST_HWRITE) && ch_last && d_ge);
   assign mod_dvd   = (state_ff == ST_CHECK) ? MOD_W'(wp_ff) : MOD_W'(d_ff);

   dcc1d_mod_unit #(
      .DVD_W(MOD_W),
      .DVS_W(ORD_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dvd),
      .divisor   (order_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Floor shift of the accumulator and saturation to 16 bits.
   always_comb begin
      shifted_c = acc_ff[ACC_W-1:FRAC_BITS];
      if ((&shifted_c[SH_W-1:VALUE_W-1]) || !(|shifted_c[SH_W-1:VALUE_W-1])) begin
         sat_c = shifted_c[VALUE_W-1:0];
      end else if (shifted_c[SH_W-1]) begin
         sat_c = {1'b1, {(VALUE_W - 1){1'b0}}};
      end else begin
         sat_c = {1'b0, {(VALUE_W - 1){1'b1}}};
      end
   end

   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // Sequencer: sweep, request handling, frame walk and result transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + CLR_W'(1);
               if (clr_cnt_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire && (req_data.func == FUNC_PUSH)) begin
                  ic_ff    <= req_data.in_index;
                  val_ff   <= req_data.value;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (ch_unused) begin
                  state_ff <= ST_IDLE;
               end else if (wp_ge) begin
                  state_ff <= ST_PMOD;
               end else begin
                  p_ff     <= wp_ff;
                  state_ff <= ST_HWRITE;
               end
            end
            ST_PMOD: begin
               if (mod_done) begin
                  p_ff     <= POS_W'(mod_rem);
                  state_ff <= ST_HWRITE;
               end
            end
            ST_HWRITE: begin
               wp_ff <= p_ff;
               o_ff  <= '0;
               if (!ch_last) begin
                  state_ff <= ST_IDLE;
               end else if (d_ge) begin
                  state_ff <= ST_DMOD;
               end else begin
                  dm_ff    <= POS_W'(d_ff);
                  state_ff <= ST_OSTART;
               end
            end
            ST_DMOD: begin
               if (mod_done) begin
                  dm_ff    <= POS_W'(mod_rem);
                  state_ff <= ST_OSTART;
               end
            end
            ST_OSTART: begin
               j_ff     <= '0;
               c_ff     <= '0;
               back_ff  <= '0;
               rp_ff    <= p_ff;
               state_ff <= ST_ISSUE;
            end
            ST_ISSUE: begin
               if (c_ff == nic_m1_ff) begin
                  c_ff <= '0;
                  if (last_mac) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     j_ff    <= j_ff + TAP_W'(1);
                     back_ff <= back_in;
                     rp_ff   <= rp_in;
                  end
               end else begin
                  c_ff <= c_ff + IC_W'(1);
               end
            end
            ST_DRAIN: begin
               if (!v1_ff && !v2_ff) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_load) begin
                  rsp_ff.result_channel <= 4'(o_ff);
                  rsp_ff.result_value   <= sat_c;
                  rsp_ff.frame_last     <= (o_ff == noc_m1_ff);
                  if (o_ff == noc_m1_ff) begin
                     wp_ff    <= wp_in;
                     state_ff <= ST_IDLE;
                  end else begin
                     o_ff     <= o_ff + OC_W'(1);
                     state_ff <= ST_OSTART;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // History RAM. Its write and its reads fall in different sequencer states,
   // so a read never meets a write to the same word.
   assign hist_we = (state_ff == ST_CLEAR) || (state_ff == ST_HWRITE);
   assign hist_wa = (state_ff == ST_CLEAR) ? clr_cnt_ff[HIST_AW-1:0] : {p_ff, IC_W'(ic_ff)};
   assign hist_wd = (state_ff == ST_CLEAR) ? '0 : val_ff;
   assign hist_ra = {rp_ff, c_ff};

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[hist_ra];
   end

   // Weight RAM, written only while the sequencer is idle or sweeping.
   assign w_we = (state_ff == ST_CLEAR) || weight_ok;
   assign w_wa = (state_ff == ST_CLEAR) ? clr_cnt_ff[W_AW-1:0] :
                 {TAP_W'(req_data.tap_index), IC_W'(req_data.in_index),
                  OC_W'(req_data.out_index)};
   assign w_wd = (state_ff == ST_CLEAR) ? '0 : req_data.value;
   assign w_ra = {j_ff, c_ff, o_ff};

   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem[w_wa] <= w_wd;
      end
      w_rd_ff <= w_mem[w_ra];
   end

   // Bias registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_OUT_CH; i++) begin
            bias_ff[i] <= '0;
         end
      end else if (bias_ok) begin
         bias_ff[OC_W'(req_data.out_index)] <= req_data.value;
      end
   end

   // Multiply-accumulate pipeline: RAM read, product, accumulate.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= (state_ff == ST_ISSUE);
         v2_ff <= v1_ff;
      end
      prod_ff <= hist_rd_ff * w_rd_ff;
      if (state_ff == ST_OSTART) begin
         acc_ff <= ACC_W'(bias_ff[o_ff]) <<< FRAC_BITS;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The accumulator must hold every product of the channel before a result
   // transfer is prepared.
   `DCC1D_ASSERT_IMPL(a_emit_drained, clock, reset, state_ff == ST_EMIT, !v1_ff && !v2_ff, "result taken before the MAC pipeline drained")
   // History reads stay inside the circular window.
   `DCC1D_ASSERT_IMPL(a_read_in_window, clock, reset, state_ff == ST_ISSUE, (ORD_W'(rp_ff) < order_ff) && (ORD_W'(back_ff) < order_ff), "history read outside the order")
   // A remainder pass always returns a value below the order.
   `DCC1D_ASSERT_IMPL(a_mod_range, clock, reset, mod_done, mod_rem < order_ff, "remainder not below the order")
   // The write position advanced at the end of a frame stays below the order.
   `DCC1D_ASSERT_NEXT(a_wp_wrap, clock, reset, rsp_load && (o_ff == noc_m1_ff), ORD_W'(wp_ff) < order_ff, "write position left the order")

endmodule

`default_nettype wire
